/* rtl/klein_pkg.sv */
// KLEIN-64 package: S-box, MixColumns, round and key schedule functions.
// Used by the round cell and the top level; no dependencies.
`default_nettype none

package klein_pkg;

	localparam int unsigned BLK_W = 64;

	typedef struct packed {
		logic [BLK_W-1:0] state;
		logic [BLK_W-1:0] key;
	} lane_t;

	function automatic logic [3:0] sbox4(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'h7;
			4'h1: y = 4'h4;
			4'h2: y = 4'hA;
			4'h3: y = 4'h9;
			4'h4: y = 4'h1;
			4'h5: y = 4'hF;
			4'h6: y = 4'hB;
			4'h7: y = 4'h0;
			4'h8: y = 4'hC;
			4'h9: y = 4'h3;
			4'hA: y = 4'h2;
			4'hB: y = 4'h6;
			4'hC: y = 4'h8;
			4'hD: y = 4'hE;
			4'hE: y = 4'hD;
			default: y = 4'h5;
		endcase
		return y;
	endfunction

	function automatic logic [7:0] sbox_byte(input logic [7:0] x);
		return {sbox4(x[7:4]), sbox4(x[3:0])};
	endfunction

	function automatic logic [BLK_W-1:0] sub_nibbles(input logic [BLK_W-1:0] x);
		logic [BLK_W-1:0] y;
		for (int k = 0; k < BLK_W / 4; k++) begin
			y[4*k +: 4] = sbox4(x[4*k +: 4]);
		end
		return y;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [31:0] mix_word(input logic [31:0] w);
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		a0 = w[31:24];
		a1 = w[23:16];
		a2 = w[15:8];
		a3 = w[7:0];
		d0 = xtime(a0);
		d1 = xtime(a1);
		d2 = xtime(a2);
		d3 = xtime(a3);
		return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
			a0 ^ d1 ^ d2 ^ a2 ^ a3,
			a0 ^ a1 ^ d2 ^ d3 ^ a3,
			d0 ^ a0 ^ a1 ^ a2 ^ d3};
	endfunction

	function automatic logic [BLK_W-1:0] round_fn(input logic [BLK_W-1:0] s,
			input logic [BLK_W-1:0] k);
		logic [BLK_W-1:0] t;
		logic [BLK_W-1:0] r;
		t = sub_nibbles(s ^ k);
		r = {t[47:0], t[63:48]};
		return {mix_word(r[63:32]), mix_word(r[31:0])};
	endfunction

	function automatic logic [BLK_W-1:0] next_key(input logic [BLK_W-1:0] k,
			input logic [7:0] ctr);
		logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
		logic [7:0] l0, l1, l2, l3, r0, r1, r2, r3;
		b0 = k[63:56];
		b1 = k[55:48];
		b2 = k[47:40];
		b3 = k[39:32];
		b4 = k[31:24];
		b5 = k[23:16];
		b6 = k[15:8];
		b7 = k[7:0];
		l0 = b5;
		l1 = b6;
		l2 = b7 ^ ctr;
		l3 = b4;
		r0 = b1 ^ b5;
		r1 = sbox_byte(b2 ^ b6);
		r2 = sbox_byte(b3 ^ b7);
		r3 = b0 ^ b4;
		return {l0, l1, l2, l3, r0, r1, r2, r3};
	endfunction

endpackage

`default_nettype wire

/* rtl/klein_if.sv */
// Valid/ready channel interfaces for the KLEIN-64 block: key and plaintext in,
// ciphertext out. No dependencies.
`default_nettype none

interface klein_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] key_word;
	logic [63:0] plain_block;

	modport source (output valid, output key_word, output plain_block, input ready);
	modport sink   (input valid, input key_word, input plain_block, output ready);
endinterface

interface klein_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_block;

	modport source (output valid, output cipher_block, input ready);
	modport sink   (input valid, input cipher_block, output ready);
endinterface

`default_nettype wire

/* rtl/klein_round_cell.sv */
// One KLEIN-64 round cell: holds a state/key pair, applies one round and one
// key update per beat. Depends on klein_pkg.
`default_nettype none

module klein_round_cell #(
	parameter logic [7:0] RND_CTR = 8'd1
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   up_valid,
	output logic                  up_ready,
	input  wire klein_pkg::lane_t up_lane,
	output logic                  dn_valid,
	input  wire                   dn_ready,
	output klein_pkg::lane_t      dn_lane
);

	logic             valid_q;
	klein_pkg::lane_t lane_q;
	logic             load;

	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lane_q.state <= klein_pkg::round_fn(up_lane.state, up_lane.key);
			lane_q.key   <= klein_pkg::next_key(up_lane.key, RND_CTR);
		end
	end

	assign dn_valid = valid_q;
	assign dn_lane  = lane_q;

endmodule

`default_nettype wire

/* rtl/klein64_block_encrypt.sv */
// KLEIN-64 encryption top level: a chain of ROUNDS round cells and an output
// register with the final key XOR. Depends on klein_pkg, klein_if, klein_round_cell.
//
//   channel   dir   beat contents
//   blk_in    in    key_word[63:0], plain_block[63:0]
//   blk_out   out   cipher_block[63:0]
//
// One block accepted per cycle unless back-pressure stalls the chain; one cell per round
// plus the output register. Each cell stalls only while it is full and the
// next one cannot take its beat, so bubbles collapse. Reset empties every stage.
`default_nettype none

module klein64_block_encrypt #(
	parameter int unsigned ROUNDS = 12
) (
	input  wire               clk,
	input  wire               arst_n,
	klein_in_if.sink          blk_in,
	klein_out_if.source       blk_out
);

	klein_pkg::lane_t lane [0:ROUNDS];
	logic             vld  [0:ROUNDS];
	logic             rdy  [0:ROUNDS];

	logic        out_valid_q;
	logic [63:0] cipher_q;

	assign lane[0].state = blk_in.plain_block;
	assign lane[0].key   = blk_in.key_word;
	assign vld[0]        = blk_in.valid;
	assign blk_in.ready  = rdy[0];

	for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
		klein_round_cell #(
			.RND_CTR(8'(i + 1))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_lane  (lane[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_lane  (lane[i+1])
		);
	end

	assign rdy[ROUNDS] = !out_valid_q || blk_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[ROUNDS]) begin
			out_valid_q <= vld[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ROUNDS] && vld[ROUNDS]) begin
			cipher_q <= lane[ROUNDS].state ^ lane[ROUNDS].key;
		end
	end

	assign blk_out.valid        = out_valid_q;
	assign blk_out.cipher_block = cipher_q;

endmodule

`default_nettype wire

/* rtl/klein_checker.sv */
// Port-level checker for klein64_block_encrypt, bound to the top level.
// Tracks beats in flight; no package dependency.
`default_nettype none

module klein_checker #(
	parameter int unsigned ROUNDS = 12
) (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [63:0] cipher_block
);

	localparam int unsigned DEPTH = ROUNDS + 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             in_beat;
	logic             out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_beat && !in_beat) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_block))
		else $error("output beat dropped or changed while stalled");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(DEPTH))
		else $error("more blocks in flight than pipeline stages");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("output beat with no block in flight");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CNT_W'(DEPTH) && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline full and stalled");

	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CNT_W'(DEPTH) |-> out_valid)
		else $error("pipeline full but no output beat offered");

endmodule

bind klein64_block_encrypt klein_checker #(
	.ROUNDS(ROUNDS)
) u_klein_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (blk_in.valid),
	.in_ready     (blk_in.ready),
	.out_valid    (blk_out.valid),
	.out_ready    (blk_out.ready),
	.cipher_block (blk_out.cipher_block)
);

`default_nettype wire

/* dv/klein64_block_encrypt_tb.sv */
// Testbench for klein64_block_encrypt: directed and random key/plaintext beats with an
// independent KLEIN-64 encryptor predicting each ciphertext, random stalls on both sides.
// Depends on klein_pkg, klein_if and the klein64_block_encrypt RTL.

module klein64_block_encrypt_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BLK_W       = klein_pkg::BLK_W;

	localparam int unsigned ROUNDS      = 12;
	localparam int unsigned RAND_ITEMS  = 2000;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = ROUNDS + 8;
	// nibble i of the table holds S(i)
	localparam logic [63:0] SBOX_TABLE  = 64'h5DE8_623C_0BF1_9A47;

	typedef struct packed {
		logic [BLK_W-1:0] key_word;
		logic [BLK_W-1:0] plain_block;
	} enc_req_t;

	logic clk;
	logic arst_n;

	klein_in_if  in_ch();
	klein_out_if out_ch();

	klein64_block_encrypt #(
		.ROUNDS(ROUNDS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.blk_in (in_ch),
		.blk_out(out_ch)
	);

	enc_req_t         req_queue[$];
	logic [BLK_W-1:0] cipher_expected[$];
	int unsigned      total_items;
	int unsigned      in_cnt;
	int unsigned      err_cnt;
	int unsigned      quiet_cycles;
	bit               in_taken;

	function automatic logic [3:0] nib_sub(input logic [3:0] x);
		return SBOX_TABLE[{x, 2'b00} +: 4];
	endfunction

	function automatic logic [7:0] byte_sub(input logic [7:0] x);
		return {nib_sub(x[7:4]), nib_sub(x[3:0])};
	endfunction

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		logic [7:0] d;
		d = v << 1;
		if (v[7])
			d = d ^ 8'h1B;
		return d;
	endfunction

	function automatic logic [31:0] mix_column(input logic [31:0] w);
		logic [7:0] a [4];
		logic [7:0] d [4];
		for (int i = 0; i < 4; i++) begin
			a[i] = w[31-8*i -: 8];
			d[i] = gf_double(a[i]);
		end
		return {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3],
			a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3],
			a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3],
			d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3]};
	endfunction

	function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] k,
			input logic [7:0] ctr);
		logic [7:0]       b [8];
		logic [7:0]       lh [4];
		logic [7:0]       rh [4];
		logic [BLK_W-1:0] o;
		for (int i = 0; i < 8; i++)
			b[i] = k[63-8*i -: 8];
		for (int i = 0; i < 4; i++) begin
			lh[i] = b[4 + ((i + 1) % 4)];
			rh[i] = b[(i + 1) % 4] ^ lh[i];
		end
		lh[2] = lh[2] ^ ctr;
		rh[1] = byte_sub(rh[1]);
		rh[2] = byte_sub(rh[2]);
		o = '0;
		for (int i = 0; i < 4; i++) begin
			o[63-8*i -: 8] = lh[i];
			o[31-8*i -: 8] = rh[i];
		end
		return o;
	endfunction

	function automatic logic [BLK_W-1:0] klein_encrypt(input enc_req_t req);
		logic [BLK_W-1:0] s;
		logic [BLK_W-1:0] k;
		logic [BLK_W-1:0] t;
		logic [7:0]       ctr;
		s = req.plain_block;
		k = req.key_word;
		for (int unsigned n = 1; n <= ROUNDS; n++) begin
			ctr = n[7:0];
			for (int j = 0; j < 16; j++)
				t[4*j +: 4] = nib_sub(s[4*j +: 4] ^ k[4*j +: 4]);
			t = {t[47:0], t[63:48]};
			s = {mix_column(t[63:32]), mix_column(t[31:0])};
			k = key_step(k, ctr);
		end
		return s ^ k;
	endfunction

	function automatic logic [BLK_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned idle_pct(input bit is_sender);
		int unsigned ph;
		ph = (in_cnt < total_items / 3) ? 0 : (in_cnt < 2 * total_items / 3) ? 1 : 2;
		case (ph)
			0: begin
				return is_sender ? 22 : 48;
			end
			1: begin
				return is_sender ? 48 : 22;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [BLK_W-1:0] exp_v,
			input logic [BLK_W-1:0] got_v);
		$display("[%0t] MISMATCH %s: expected %016h got %016h", $realtime, what, exp_v, got_v);
		err_cnt++;
	endtask

	always #1 clk = ~clk;

	// input side: sample at rising edge, drive at falling edge
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			cipher_expected.push_back(klein_encrypt({in_ch.key_word, in_ch.plain_block}));
			in_cnt++;
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		enc_req_t req;
		if (arst_n && (!in_ch.valid || in_taken)) begin
			in_taken = 1'b0;
			if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
				req = req_queue.pop_front();
				in_ch.valid       <= 1'b1;
				in_ch.key_word    <= req.key_word;
				in_ch.plain_block <= req.plain_block;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// output side
	always @(posedge clk) begin
		logic [BLK_W-1:0] exp_v;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (cipher_expected.size() == 0) begin
				report_mismatch("unexpected beat", '0, out_ch.cipher_block);
			end else begin
				exp_v = cipher_expected.pop_front();
				if (out_ch.cipher_block !== exp_v)
					report_mismatch("cipher_block", exp_v, out_ch.cipher_block);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		enc_req_t         req;
		logic [BLK_W-1:0] last_key;
		int unsigned      pick;
		clk               = 1'b0;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.key_word    = '0;
		in_ch.plain_block = '0;
		out_ch.ready      = 1'b0;
		in_cnt            = 0;
		err_cnt           = 0;
		quiet_cycles      = 0;
		in_taken          = 1'b0;

		req_queue.push_back('{'0, '0});
		req_queue.push_back('{'1, '1});
		req_queue.push_back('{'0, '1});
		req_queue.push_back('{'1, '0});
		req_queue.push_back('{64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A});
		req_queue.push_back('{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210});
		req_queue.push_back('{64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001});
		req_queue.push_back('{64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000});
		// every S-box input in every nibble
		for (int n = 0; n < 16; n++)
			req_queue.push_back('{'0, {16{n[3:0]}}});

		last_key = rand_word();
		for (int i = 0; i < RAND_ITEMS; i++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				last_key = rand_word();
			else if (pick < 85)
				last_key = 64'd1 << (8 * $urandom_range(7)) << $urandom_range(7);
			req.key_word    = last_key;
			req.plain_block = ($urandom_range(19) == 0) ? ~64'd0 << $urandom_range(63)
				: rand_word();
			req_queue.push_back(req);
		end
		total_items = req_queue.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_queue.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (cipher_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
